### sv/sdr_pkg.sv
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared widths, register indexes, direction codes and types of the
// steepest descent receiver.
// ----------------------------------------------------------------------------
package sdr_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int ELEV_BITS_DEF = 32;

   localparam int COL_BITS = 10;
   localparam int ROW_BITS = 12;
   localparam int DIR_BITS = 4;

   localparam int CFG_W_BITS = 11;
   localparam int CFG_H_BITS = 13;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 13;

   localparam int MIN_SIZE = 3;
   localparam int MAX_HEIGHT = 4096;
   localparam int RESET_SIZE = 512;

   localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [DIR_BITS-1:0] DIR_W = 4'd0;
   localparam logic [DIR_BITS-1:0] DIR_NW = 4'd1;
   localparam logic [DIR_BITS-1:0] DIR_N = 4'd2;
   localparam logic [DIR_BITS-1:0] DIR_NE = 4'd3;
   localparam logic [DIR_BITS-1:0] DIR_E = 4'd4;
   localparam logic [DIR_BITS-1:0] DIR_SE = 4'd5;
   localparam logic [DIR_BITS-1:0] DIR_S = 4'd6;
   localparam logic [DIR_BITS-1:0] DIR_SW = 4'd7;
   localparam logic [DIR_BITS-1:0] DIR_PIT = 4'd8;

   localparam int NUM_NEIGHBORS = 8;

   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
   } cell_pos_type;

endpackage

### sv/sdr_line_buffer.sv
// ----------------------------------------------------------------------------
// sdr_line_buffer
// Two row stores in synchronous memories with one read and one write per
// cycle, a fill mark for entries not yet written and write-to-read forwarding.
// ----------------------------------------------------------------------------
module sdr_line_buffer #(
   parameter int MAX_WIDTH = sdr_pkg::MAX_WIDTH_DEF,
   parameter int ELEV_BITS = sdr_pkg::ELEV_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   output logic [ELEV_BITS-1:0]          rd_upper,
   output logic [ELEV_BITS-1:0]          rd_middle,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  logic [ELEV_BITS-1:0]          wr_upper,
   input  logic [ELEV_BITS-1:0]          wr_middle
);
   import sdr_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic [ELEV_BITS-1:0] upper_mem [MAX_WIDTH];
   logic [ELEV_BITS-1:0] middle_mem [MAX_WIDTH];

   logic [ELEV_BITS-1:0] q_upper_ff;
   logic [ELEV_BITS-1:0] q_middle_ff;
   logic [ELEV_BITS-1:0] fwd_upper_ff;
   logic [ELEV_BITS-1:0] fwd_middle_ff;
   logic                 fwd_ff;
   logic                 fwd_in;
   logic                 live_ff;
   logic                 live_in;
   logic [AW:0]          fill_ff;
   logic [AW:0]          fill_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr] <= wr_upper;
         middle_mem[wr_addr] <= wr_middle;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_upper_ff <= upper_mem[rd_addr];
         q_middle_ff <= middle_mem[rd_addr];
         fwd_upper_ff <= wr_upper;
         fwd_middle_ff <= wr_middle;
      end
   end

   // entries at or past the fill mark read as zero; the memories themselves have no reset
   always_comb begin
      fwd_in = wr_en && (wr_addr == rd_addr);
      live_in = {1'b0, rd_addr} < fill_ff;
      fill_in = fill_ff;
      if (wr_en && ({1'b0, wr_addr} >= fill_ff)) begin
         fill_in = {1'b0, wr_addr} + (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         fwd_ff <= 1'b0;
         live_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (rd_en) begin
            fwd_ff <= fwd_in;
            live_ff <= live_in;
         end
      end
   end

   assign rd_upper = fwd_ff ? fwd_upper_ff : (live_ff ? q_upper_ff : '0);
   assign rd_middle = fwd_ff ? fwd_middle_ff : (live_ff ? q_middle_ff : '0);

endmodule

### sv/sdr_pick.sv
// ----------------------------------------------------------------------------
// sdr_pick
// Steepest drop selection: diagonal scaling in two partial products, then a
// registered three-level tournament where the lower-indexed neighbor wins a tie.
// ----------------------------------------------------------------------------
module sdr_pick #(
   parameter int ELEV_BITS = sdr_pkg::ELEV_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [7:0][ELEV_BITS-1:0]           in_drop,
   input  sdr_pkg::cell_pos_type               in_pos,
   output logic                                out_valid,
   input  logic                                out_stall,
   output logic [sdr_pkg::DIR_BITS-1:0]        out_direction,
   output logic                                out_diagonal,
   output sdr_pkg::cell_pos_type               out_pos
);
   import sdr_pkg::*;

   localparam int LO = (ELEV_BITS + 1) / 2;
   localparam int HI = ELEV_BITS - LO;
   localparam int SW = ELEV_BITS + 32;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

   logic [7:0][ELEV_BITS-1:0] drop1_ff;
   cell_pos_type              pos1_ff, pos2_ff, pos3_ff, pos4_ff, pos5_ff, pos6_ff;

   logic [ELEV_BITS-1:0] card2_ff [4];
   logic [LO+31:0]       plo2_ff [4];
   logic [HI+31:0]       phi2_ff [4];
   logic [LO+31:0]       plo2_in [4];
   logic [HI+31:0]       phi2_in [4];

   logic [SW-1:0] slope3_ff [8];
   logic [SW-1:0] slope3_in [8];

   logic [SW-1:0] slope4_ff [4];
   logic [2:0]    idx4_ff [4];
   logic [SW-1:0] slope4_in [4];
   logic [2:0]    idx4_in [4];

   logic [SW-1:0] slope5_ff [2];
   logic [2:0]    idx5_ff [2];
   logic [SW-1:0] slope5_in [2];
   logic [2:0]    idx5_in [2];

   logic [SW-1:0]         best_slope;
   logic [2:0]            best_idx;
   logic [DIR_BITS-1:0]   dir6_ff;
   logic [DIR_BITS-1:0]   dir6_in;
   logic                  diag6_ff;
   logic                  diag6_in;

   assign rdy6 = !v6_ff || !out_stall;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
         if (rdy6) begin
            v6_ff <= v5_ff;
         end
      end
   end

   // odd neighbors are diagonal
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         plo2_in[j] = (LO+32)'(drop1_ff[2*j+1][LO-1:0]) * (LO+32)'(INV_SQRT2_Q32);
         phi2_in[j] = (HI+32)'(drop1_ff[2*j+1][ELEV_BITS-1:LO]) * (HI+32)'(INV_SQRT2_Q32);
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         slope3_in[2*j] = {card2_ff[j], 32'd0};
         slope3_in[2*j+1] = (SW'(phi2_ff[j]) << LO) + SW'(plo2_ff[j]);
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         if (slope3_ff[2*j+1] > slope3_ff[2*j]) begin
            slope4_in[j] = slope3_ff[2*j+1];
            idx4_in[j] = 3'(2*j+1);
         end else begin
            slope4_in[j] = slope3_ff[2*j];
            idx4_in[j] = 3'(2*j);
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         if (slope4_ff[2*j+1] > slope4_ff[2*j]) begin
            slope5_in[j] = slope4_ff[2*j+1];
            idx5_in[j] = idx4_ff[2*j+1];
         end else begin
            slope5_in[j] = slope4_ff[2*j];
            idx5_in[j] = idx4_ff[2*j];
         end
      end
   end

   // a zero slope means no positive drop anywhere: pit
   always_comb begin
      if (slope5_ff[1] > slope5_ff[0]) begin
         best_slope = slope5_ff[1];
         best_idx = idx5_ff[1];
      end else begin
         best_slope = slope5_ff[0];
         best_idx = idx5_ff[0];
      end
      if (best_slope == '0) begin
         dir6_in = DIR_PIT;
         diag6_in = 1'b0;
      end else begin
         dir6_in = DIR_BITS'(best_idx);
         diag6_in = best_idx[0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         drop1_ff <= in_drop;
         pos1_ff <= in_pos;
      end
      if (rdy2 && v1_ff) begin
         for (int j = 0; j < 4; j++) begin
            card2_ff[j] <= drop1_ff[2*j];
            plo2_ff[j] <= plo2_in[j];
            phi2_ff[j] <= phi2_in[j];
         end
         pos2_ff <= pos1_ff;
      end
      if (rdy3 && v2_ff) begin
         for (int n = 0; n < NUM_NEIGHBORS; n++) begin
            slope3_ff[n] <= slope3_in[n];
         end
         pos3_ff <= pos2_ff;
      end
      if (rdy4 && v3_ff) begin
         for (int j = 0; j < 4; j++) begin
            slope4_ff[j] <= slope4_in[j];
            idx4_ff[j] <= idx4_in[j];
         end
         pos4_ff <= pos3_ff;
      end
      if (rdy5 && v4_ff) begin
         for (int j = 0; j < 2; j++) begin
            slope5_ff[j] <= slope5_in[j];
            idx5_ff[j] <= idx5_in[j];
         end
         pos5_ff <= pos4_ff;
      end
      if (rdy6 && v5_ff) begin
         dir6_ff <= dir6_in;
         diag6_ff <= diag6_in;
         pos6_ff <= pos5_ff;
      end
   end

   assign out_valid = v6_ff;
   assign out_direction = dir6_ff;
   assign out_diagonal = diag6_ff;
   assign out_pos = pos6_ff;

endmodule

### sv/steepest_descent_receiver.sv
// ----------------------------------------------------------------------------
// steepest_descent_receiver
// D8 flow direction of a streamed elevation raster: line stores, a 3x3
// window and a pipelined steepest-drop selection, one result per interior cell.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while req_stall is low, set by the single read and write port per line store
// border words produce no result and leave the pipeline with the line store update
// reset: counters, window and pipeline cleared at once; frame size back to 512 x 512
// line stores read as zero until written, tracked by a fill mark, so no clearing pass
module steepest_descent_receiver #(
   parameter int MAX_WIDTH = sdr_pkg::MAX_WIDTH_DEF,
   parameter int ELEV_BITS = sdr_pkg::ELEV_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [ELEV_BITS-1:0]          req_elevation,
   input  logic                                 req_frame_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sdr_pkg::COL_BITS-1:0]         rsp_cell_col,
   output logic [sdr_pkg::ROW_BITS-1:0]         rsp_cell_row,
   output logic [sdr_pkg::DIR_BITS-1:0]         rsp_direction,
   output logic                                 rsp_diagonal,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sdr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sdr_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import sdr_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = AW + 1;
   localparam int DW = ELEV_BITS + 1;
   localparam int NB_BITS = $clog2(NUM_NEIGHBORS);
   localparam int WIDTH_RESET = (RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE;

   // frame size, held already clamped
   logic [WW-1:0]         eff_w_ff;
   logic [WW-1:0]         eff_w_in;
   logic [CFG_H_BITS-1:0] eff_h_ff;
   logic [CFG_H_BITS-1:0] eff_h_in;
   logic [CFG_W_BITS-1:0] width_raw;
   logic [CFG_H_BITS-1:0] height_raw;

   logic [AW-1:0]         col_ff;
   logic [AW-1:0]         col_in;
   logic [ROW_BITS-1:0]   row_ff;
   logic [ROW_BITS-1:0]   row_in;
   logic [AW-1:0]         c0;
   logic [ROW_BITS-1:0]   r0;
   logic [WW-1:0]         col_next;
   logic [CFG_H_BITS-1:0] row_next;
   logic                  emit0;

   logic                        accept;
   logic                        s1_valid_ff;
   logic                        s1_emit_ff;
   logic [AW-1:0]               s1_col_ff;
   logic [ROW_BITS-1:0]         s1_row_ff;
   logic signed [ELEV_BITS-1:0] s1_cur_ff;
   logic                        s1_go;
   logic                        s1_ready;
   logic                        s1_leave;

   logic [ELEV_BITS-1:0]        line_upper;
   logic [ELEV_BITS-1:0]        line_middle;

   // window: 0,1 upper  2,3 middle  4,5 current; even entries two columns back
   logic signed [ELEV_BITS-1:0] win_ff [6];
   logic signed [ELEV_BITS-1:0] center;
   logic signed [ELEV_BITS-1:0] nb [NUM_NEIGHBORS];
   logic signed [DW-1:0]        diff [NUM_NEIGHBORS];
   logic [7:0][ELEV_BITS-1:0]   drop_bus;

   logic                        pick_ready;
   cell_pos_type                pick_pos;
   cell_pos_type                out_pos;

   // configuration
   assign csr_ready = 1'b1;
   assign width_raw = csr_data[CFG_W_BITS-1:0];
   assign height_raw = csr_data[CFG_H_BITS-1:0];

   always_comb begin
      if (32'(width_raw) < MIN_SIZE) begin
         eff_w_in = WW'(MIN_SIZE);
      end else if (32'(width_raw) > MAX_WIDTH) begin
         eff_w_in = WW'(MAX_WIDTH);
      end else begin
         eff_w_in = WW'(width_raw);
      end
      if (32'(height_raw) < MIN_SIZE) begin
         eff_h_in = CFG_H_BITS'(MIN_SIZE);
      end else if (32'(height_raw) > MAX_HEIGHT) begin
         eff_h_in = CFG_H_BITS'(MAX_HEIGHT);
      end else begin
         eff_h_in = height_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff <= WW'(WIDTH_RESET);
         eff_h_ff <= CFG_H_BITS'(RESET_SIZE);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               eff_w_ff <= eff_w_in;
            end
            CSR_FRAME_HEIGHT: begin
               eff_h_ff <= eff_h_in;
            end
            default: begin
            end
         endcase
      end
   end

   // raster position of the incoming word
   always_comb begin
      c0 = req_frame_start ? '0 : col_ff;
      r0 = req_frame_start ? '0 : row_ff;
      emit0 = (c0 >= AW'(2)) && (r0 >= ROW_BITS'(2)) &&
              (WW'(c0) < eff_w_ff) && (CFG_H_BITS'(r0) < eff_h_ff);
      col_next = WW'(c0) + WW'(1);
      row_next = CFG_H_BITS'(r0) + CFG_H_BITS'(1);
      if (col_next >= eff_w_ff) begin
         col_in = '0;
         row_in = (row_next >= eff_h_ff) ? '0 : ROW_BITS'(row_next);
      end else begin
         col_in = AW'(col_next);
         row_in = r0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // word stage: line store data arrives, window completes
   assign s1_go = !s1_emit_ff || pick_ready;
   assign s1_ready = !s1_valid_ff || s1_go;
   assign s1_leave = s1_valid_ff && s1_go;
   assign accept = req_valid && s1_ready;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
         s1_emit_ff <= req_valid && emit0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff <= c0;
         s1_row_ff <= r0;
         s1_cur_ff <= req_elevation;
      end
   end

   sdr_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH),
      .ELEV_BITS (ELEV_BITS)
   ) u_line_buffer (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (c0),
      .rd_upper  (line_upper),
      .rd_middle (line_middle),
      .wr_en     (s1_leave),
      .wr_addr   (s1_col_ff),
      .wr_upper  (line_middle),
      .wr_middle (s1_cur_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_leave) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= line_upper;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= line_middle;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= s1_cur_ff;
      end
   end

   // neighbors in search order W, NW, N, NE, E, SE, S, SW
   always_comb begin
      center = win_ff[3];
      nb[NB_BITS'(DIR_W)] = win_ff[2];
      nb[NB_BITS'(DIR_NW)] = win_ff[0];
      nb[NB_BITS'(DIR_N)] = win_ff[1];
      nb[NB_BITS'(DIR_NE)] = line_upper;
      nb[NB_BITS'(DIR_E)] = line_middle;
      nb[NB_BITS'(DIR_SE)] = s1_cur_ff;
      nb[NB_BITS'(DIR_S)] = win_ff[5];
      nb[NB_BITS'(DIR_SW)] = win_ff[4];
      for (int n = 0; n < NUM_NEIGHBORS; n++) begin
         diff[n] = DW'(center) - DW'(nb[n]);
         drop_bus[n] = (center > nb[n]) ? ELEV_BITS'(diff[n]) : '0;
      end
   end

   assign pick_pos.col = COL_BITS'(s1_col_ff - AW'(1));
   assign pick_pos.row = s1_row_ff - ROW_BITS'(1);

   sdr_pick #(
      .ELEV_BITS (ELEV_BITS)
   ) u_pick (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s1_valid_ff && s1_emit_ff),
      .in_ready      (pick_ready),
      .in_drop       (drop_bus),
      .in_pos        (pick_pos),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_direction (rsp_direction),
      .out_diagonal  (rsp_diagonal),
      .out_pos       (out_pos)
   );

   assign rsp_cell_col = out_pos.col;
   assign rsp_cell_row = out_pos.row;

endmodule

### sv/sdr_checker.sv
// ----------------------------------------------------------------------------
// sdr_checker
// Port-level checks on the result channel of the steepest descent receiver.
// ----------------------------------------------------------------------------
module sdr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [sdr_pkg::COL_BITS-1:0]  rsp_cell_col,
   input logic [sdr_pkg::ROW_BITS-1:0]  rsp_cell_row,
   input logic [sdr_pkg::DIR_BITS-1:0]  rsp_direction,
   input logic                          rsp_diagonal
);
   import sdr_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_col) &&
      $stable(rsp_cell_row) && $stable(rsp_direction) && $stable(rsp_diagonal))
      else $error("result word changed under stall");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // diagonal flag follows the direction code
   a_diag_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_direction == DIR_PIT && !rsp_diagonal) ||
      (rsp_direction < DIR_PIT && rsp_diagonal == rsp_direction[0]))
      else $error("diagonal flag does not match direction");

   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cell_col != '0 && rsp_cell_row != '0)
      else $error("result for a border cell");

endmodule

bind steepest_descent_receiver sdr_checker u_sdr_checker (.*);
